### rtl/core/erb_pkg.sv
// ----------------------------------------------------------------------------
// erb_pkg
// Shared types and constants for the Euler basis rotation pipeline.
// ----------------------------------------------------------------------------
package erb_pkg;

    localparam int ERB_STEPS = 14;               // cordic iterations, 8..24
    localparam int ERB_LAT   = ERB_STEPS + 7;    // input word to output word
    localparam int ERB_DLY   = ERB_STEPS + 6;    // basis delay line length
    localparam int ERB_W     = 36;               // cordic datapath width

    localparam logic signed [ERB_W-1:0] ERB_PI      = 36'sd3373259426;
    localparam logic signed [ERB_W-1:0] ERB_HALF_PI = 36'sd1686629713;
    localparam logic signed [ERB_W-1:0] ERB_GAIN    = 36'sd652032874;

    localparam logic [31:0] ERB_ATAN [0:23] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
        32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
        32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
        32'd262143,    32'd131071,    32'd65535,     32'd32767,
        32'd16383,     32'd8191,      32'd4095,      32'd2047,
        32'd1023,      32'd511,       32'd255,       32'd127
    };

    typedef struct packed {
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
        logic signed [15:0] at_x;
        logic signed [15:0] at_y;
        logic signed [15:0] at_z;
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
    } t_erb_in;

    typedef struct packed {
        logic signed [15:0] new_right_x;
        logic signed [15:0] new_right_y;
        logic signed [15:0] new_right_z;
        logic signed [15:0] new_up_x;
        logic signed [15:0] new_up_y;
        logic signed [15:0] new_up_z;
        logic signed [15:0] new_at_x;
        logic signed [15:0] new_at_y;
        logic signed [15:0] new_at_z;
    } t_erb_out;

    // basis field k in input order, right_x first
    function automatic logic signed [15:0] erb_basis(input t_erb_in d, input int k);
        logic signed [15:0] v;
        unique case (k)
            0:       v = d.right_x;
            1:       v = d.right_y;
            2:       v = d.right_z;
            3:       v = d.up_x;
            4:       v = d.up_y;
            5:       v = d.up_z;
            6:       v = d.at_x;
            7:       v = d.at_y;
            default: v = d.at_z;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/erb_in_if.sv
// ----------------------------------------------------------------------------
// erb_in_if
// Input channel: valid/ready handshake carrying basis and angles.
// ----------------------------------------------------------------------------
interface erb_in_if import erb_pkg::*; ();
    logic    valid;
    logic    ready;
    t_erb_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/erb_out_if.sv
// ----------------------------------------------------------------------------
// erb_out_if
// Output channel: valid/ready handshake carrying the rotated basis.
// ----------------------------------------------------------------------------
interface erb_out_if import erb_pkg::*; ();
    logic     valid;
    logic     ready;
    t_erb_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/erb_cordic.sv
// ----------------------------------------------------------------------------
// erb_cordic
// Pipelined sine/cosine lane: range fold, one stage per iteration, rounding.
// ----------------------------------------------------------------------------
module erb_cordic import erb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_angle,
    output logic signed [17:0] o_sin,
    output logic signed [17:0] o_cos
);

    logic signed [ERB_W-1:0] r_x [0:ERB_STEPS];
    logic signed [ERB_W-1:0] r_y [0:ERB_STEPS];
    logic signed [ERB_W-1:0] r_z [0:ERB_STEPS-1];
    logic                    r_f [0:ERB_STEPS];

    logic signed [ERB_W-1:0] n_z;
    logic                    n_f;
    logic signed [ERB_W-1:0] n_xo;
    logic signed [ERB_W-1:0] n_yo;
    logic signed [ERB_W-1:0] n_xr;
    logic signed [ERB_W-1:0] n_yr;

    // fold into [-pi/2, pi/2] in three passes
    always_comb begin
        n_z = ERB_W'($signed({i_angle, 18'b0}));
        n_f = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (n_z > ERB_HALF_PI) begin
                n_z = n_z - ERB_PI;
                n_f = ~n_f;
            end else if (n_z < -ERB_HALF_PI) begin
                n_z = n_z + ERB_PI;
                n_f = ~n_f;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= ERB_GAIN;
            r_y[0] <= '0;
            r_z[0] <= n_z;
            r_f[0] <= n_f;
        end
    end

    for (genvar gi = 0; gi < ERB_STEPS; gi++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[gi][ERB_W-1]) begin
                    r_x[gi+1] <= r_x[gi] - (r_y[gi] >>> gi);
                    r_y[gi+1] <= r_y[gi] + (r_x[gi] >>> gi);
                end else begin
                    r_x[gi+1] <= r_x[gi] + (r_y[gi] >>> gi);
                    r_y[gi+1] <= r_y[gi] - (r_x[gi] >>> gi);
                end
                r_f[gi+1] <= r_f[gi];
            end
        end

        // the last step needs no residual angle
        if (gi < ERB_STEPS - 1) begin : g_z
            localparam logic signed [ERB_W-1:0] ATAN_I =
                ERB_W'($signed({1'b0, ERB_ATAN[gi]}));
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!r_z[gi][ERB_W-1]) begin
                        r_z[gi+1] <= r_z[gi] - ATAN_I;
                    end else begin
                        r_z[gi+1] <= r_z[gi] + ATAN_I;
                    end
                end
            end
        end
    end

    always_comb begin
        n_xo = r_f[ERB_STEPS] ? -r_x[ERB_STEPS] : r_x[ERB_STEPS];
        n_yo = r_f[ERB_STEPS] ? -r_y[ERB_STEPS] : r_y[ERB_STEPS];
        n_xr = (n_xo + ERB_W'(32768)) >>> 16;
        n_yr = (n_yo + ERB_W'(32768)) >>> 16;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sin <= n_yr[17:0];
            o_cos <= n_xr[17:0];
        end
    end

endmodule

### rtl/core/erb_mat.sv
// ----------------------------------------------------------------------------
// erb_mat
// Builds the XYZ Euler matrix in Q.28 from three sine/cosine pairs.
// ----------------------------------------------------------------------------
module erb_mat import erb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [17:0] i_sx,
    input  logic signed [17:0] i_cx,
    input  logic signed [17:0] i_sy,
    input  logic signed [17:0] i_cy,
    input  logic signed [17:0] i_sz,
    input  logic signed [17:0] i_cz,
    output logic signed [31:0] o_r [3][3]
);

    // pair products
    logic signed [35:0] r_cycz, r_cysz, r_sxsy, r_cxsz, r_cxsy, r_sxsz, r_sxcz;
    logic signed [35:0] r_cxcz, r_sxcy, r_cxcy;
    logic signed [17:0] r_sy, r_sz, r_cz;
    // triple products and carried terms
    logic signed [53:0] r_m10, r_m11, r_m20, r_m21;
    logic signed [35:0] r_b_cycz, r_b_cysz, r_b_cxsz, r_b_sxsz, r_b_sxcz;
    logic signed [35:0] r_b_cxcz, r_b_sxcy, r_b_cxcy;
    logic signed [17:0] r_b_sy;

    logic signed [55:0] n_s10, n_s11, n_s20, n_s21;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cycz <= i_cy * i_cz;
            r_cysz <= i_cy * i_sz;
            r_sxsy <= i_sx * i_sy;
            r_cxsz <= i_cx * i_sz;
            r_cxsy <= i_cx * i_sy;
            r_sxsz <= i_sx * i_sz;
            r_sxcz <= i_sx * i_cz;
            r_cxcz <= i_cx * i_cz;
            r_sxcy <= i_sx * i_cy;
            r_cxcy <= i_cx * i_cy;
            r_sy   <= i_sy;
            r_sz   <= i_sz;
            r_cz   <= i_cz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m10    <= r_sxsy * r_cz;
            r_m11    <= r_sxsy * r_sz;
            r_m20    <= r_cxsy * r_cz;
            r_m21    <= r_cxsy * r_sz;
            r_b_cycz <= r_cycz;
            r_b_cysz <= r_cysz;
            r_b_cxsz <= r_cxsz;
            r_b_sxsz <= r_sxsz;
            r_b_sxcz <= r_sxcz;
            r_b_cxcz <= r_cxcz;
            r_b_sxcy <= r_sxcy;
            r_b_cxcy <= r_cxcy;
            r_b_sy   <= r_sy;
        end
    end

    // three-factor entries: Q.42 sum, round back to Q.28
    always_comb begin
        n_s10 = (56'(r_m10) + (56'(r_b_cxsz) <<< 14) + 56'sd8192) >>> 14;
        n_s11 = (-56'(r_m11) + (56'(r_b_cxcz) <<< 14) + 56'sd8192) >>> 14;
        n_s20 = (-56'(r_m20) + (56'(r_b_sxsz) <<< 14) + 56'sd8192) >>> 14;
        n_s21 = (56'(r_m21) + (56'(r_b_sxcz) <<< 14) + 56'sd8192) >>> 14;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_r[0][0] <= r_b_cycz[31:0];
            o_r[0][1] <= 32'(-r_b_cysz);
            o_r[0][2] <= 32'(r_b_sy) <<< 14;
            o_r[1][0] <= n_s10[31:0];
            o_r[1][1] <= n_s11[31:0];
            o_r[1][2] <= 32'(-r_b_sxcy);
            o_r[2][0] <= n_s20[31:0];
            o_r[2][1] <= n_s21[31:0];
            o_r[2][2] <= r_b_cxcy[31:0];
        end
    end

endmodule

### rtl/core/erb_dot.sv
// ----------------------------------------------------------------------------
// erb_dot
// One output lane: three products, then sum, round, saturate or pass through.
// ----------------------------------------------------------------------------
module erb_dot import erb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_b0,
    input  logic signed [15:0] i_b1,
    input  logic signed [15:0] i_b2,
    input  logic signed [31:0] i_r0,
    input  logic signed [31:0] i_r1,
    input  logic signed [31:0] i_r2,
    input  logic               i_pass,
    input  logic signed [15:0] i_pass_val,
    output logic signed [15:0] o_res
);

    logic signed [47:0] r_p0, r_p1, r_p2;
    logic signed [49:0] n_sum;
    logic signed [49:0] n_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0 <= i_b0 * i_r0;
            r_p1 <= i_b1 * i_r1;
            r_p2 <= i_b2 * i_r2;
        end
    end

    always_comb begin
        n_sum = 50'(r_p0) + 50'(r_p1) + 50'(r_p2) + 50'sd134217728;
        n_v   = n_sum >>> 28;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            priority if (i_pass) begin
                o_res <= i_pass_val;
            end else if (n_v > 50'sd32767) begin
                o_res <= 16'sh7fff;
            end else if (n_v < -50'sd32768) begin
                o_res <= 16'sh8000;
            end else begin
                o_res <= n_v[15:0];
            end
        end
    end

endmodule

### rtl/core/euler_rotate_basis.sv
// throughput: one word per cycle; the whole pipeline holds while an output word waits
// stages: angle fold, one stage per cordic step, rounding, three matrix stages,
//   products, and the sum/saturate output register
// reset: synchronous active-low i_rst_n clears the stage valid bits only
// ----------------------------------------------------------------------------
// euler_rotate_basis
// Rotates a 3x3 basis by an XYZ Euler rotation built from cordic sin/cos.
// ----------------------------------------------------------------------------
module euler_rotate_basis import erb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    erb_in_if.sink    i_in,
    erb_out_if.source o_out
);

    logic                en;
    logic [ERB_LAT-1:0]  r_vld;
    t_erb_in             r_bas  [0:ERB_DLY-1];
    logic                r_zero [0:ERB_DLY-1];
    logic signed [17:0]  sx, cx, sy, cy, sz, cz;
    logic signed [31:0]  r_m [3][3];
    logic signed [15:0]  res [9];

    assign en          = !r_vld[ERB_LAT-1] || o_out.ready;
    // no word is taken while reset is held
    assign i_in.ready  = en && i_rst_n;
    assign o_out.valid = r_vld[ERB_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[ERB_LAT-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bas[0]  <= i_in.data;
            r_zero[0] <= (i_in.data.angle_x == '0) && (i_in.data.angle_y == '0)
                         && (i_in.data.angle_z == '0);
            for (int k = 1; k < ERB_DLY; k++) begin
                r_bas[k]  <= r_bas[k-1];
                r_zero[k] <= r_zero[k-1];
            end
        end
    end

    erb_cordic u_cx (.i_clk, .i_en(en), .i_angle(i_in.data.angle_x), .o_sin(sx), .o_cos(cx));
    erb_cordic u_cy (.i_clk, .i_en(en), .i_angle(i_in.data.angle_y), .o_sin(sy), .o_cos(cy));
    erb_cordic u_cz (.i_clk, .i_en(en), .i_angle(i_in.data.angle_z), .o_sin(sz), .o_cos(cz));

    erb_mat u_mat (
        .i_clk, .i_en(en),
        .i_sx(sx), .i_cx(cx), .i_sy(sy), .i_cy(cy), .i_sz(sz), .i_cz(cz),
        .o_r(r_m)
    );

    // lane k: column j of the matrix, component i of the basis
    for (genvar gk = 0; gk < 9; gk++) begin : g_lane
        localparam int J = gk / 3;
        localparam int I = gk % 3;
        erb_dot u_dot (
            .i_clk, .i_en(en),
            .i_b0(erb_basis(r_bas[ERB_DLY-2], I)),
            .i_b1(erb_basis(r_bas[ERB_DLY-2], 3 + I)),
            .i_b2(erb_basis(r_bas[ERB_DLY-2], 6 + I)),
            .i_r0(r_m[0][J]), .i_r1(r_m[1][J]), .i_r2(r_m[2][J]),
            .i_pass(r_zero[ERB_DLY-1]),
            .i_pass_val(erb_basis(r_bas[ERB_DLY-1], gk)),
            .o_res(res[gk])
        );
    end

    assign o_out.data.new_right_x = res[0];
    assign o_out.data.new_right_y = res[1];
    assign o_out.data.new_right_z = res[2];
    assign o_out.data.new_up_x    = res[3];
    assign o_out.data.new_up_y    = res[4];
    assign o_out.data.new_up_z    = res[5];
    assign o_out.data.new_at_x    = res[6];
    assign o_out.data.new_at_y    = res[7];
    assign o_out.data.new_at_z    = res[8];

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_vld[ERB_LAT-2] |=> r_vld[ERB_LAT-1])
        else $error("word lost before the output stage");

    a_hold_vld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> $stable(o_out.data))
        else $error("output word changed while stalled");

endmodule

### test/tb_erb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb interfaces
// Testbench copies are not needed: the block's own channel interfaces are used.
// This file holds the small helper type shared by the bench.
// ----------------------------------------------------------------------------
package tb_erb_pkg;
    import erb_pkg::*;

    // one queued expected rotated basis with the input that caused it
    typedef struct packed {
        t_erb_out res;
        t_erb_in  src;
    } t_rot_expect;
endpackage

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives basis and angle words into the rotation pipeline with random gaps,
// predicts each rotated basis in fixed point, and checks every output word.
// ----------------------------------------------------------------------------
module tb;
    import erb_pkg::*;
    import tb_erb_pkg::*;

    localparam longint PI_FX   = 64'sd3373259426;
    localparam longint HPI_FX  = 64'sd1686629713;
    localparam longint GAIN_FX = 64'sd652032874;
    localparam longint ATAN_FX [0:23] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    erb_in_if  in_ch ();
    erb_out_if out_ch ();

    euler_rotate_basis dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    t_rot_expect rotated_q[$];
    int  n_errors = 0;
    int  idle_pct = 13;

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
    end

    function automatic void sin_cos(input logic signed [15:0] ang,
                                    output longint s, output longint c);
        longint z, x, y, xs, ys;
        bit flip;
        z = longint'(ang) * 262144;
        x = GAIN_FX;
        y = 0;
        flip = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (z > HPI_FX) begin
                z -= PI_FX;
                flip = ~flip;
            end else if (z < -HPI_FX) begin
                z += PI_FX;
                flip = ~flip;
            end
        end
        for (int i = 0; i < ERB_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= ATAN_FX[i];
            end else begin
                x += ys; y -= xs; z += ATAN_FX[i];
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        s = (y + 32768) >>> 16;
        c = (x + 32768) >>> 16;
    endfunction

    function automatic logic signed [15:0] round_sat(input longint acc);
        longint v;
        v = (acc + 134217728) >>> 28;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic t_erb_out rotate_basis(input t_erb_in d);
        longint b [9];
        longint sx, cx, sy, cy, sz, cz;
        longint r [3][3];
        logic signed [15:0] o [9];
        t_erb_out res;
        b = '{d.right_x, d.right_y, d.right_z, d.up_x, d.up_y, d.up_z,
              d.at_x, d.at_y, d.at_z};
        if (d.angle_x == 0 && d.angle_y == 0 && d.angle_z == 0) begin
            for (int i = 0; i < 9; i++) o[i] = b[i][15:0];
        end else begin
            sin_cos(d.angle_x, sx, cx);
            sin_cos(d.angle_y, sy, cy);
            sin_cos(d.angle_z, sz, cz);
            r[0][0] = cy * cz;
            r[0][1] = -(cy * sz);
            r[0][2] = sy * 16384;
            r[1][0] = (sx * sy * cz + cx * sz * 16384 + 8192) >>> 14;
            r[1][1] = (-(sx * sy * sz) + cx * cz * 16384 + 8192) >>> 14;
            r[1][2] = -(sx * cy);
            r[2][0] = (-(cx * sy * cz) + sx * sz * 16384 + 8192) >>> 14;
            r[2][1] = (cx * sy * sz + sx * cz * 16384 + 8192) >>> 14;
            r[2][2] = cx * cy;
            for (int j = 0; j < 3; j++)
                for (int i = 0; i < 3; i++)
                    o[j*3+i] = round_sat(b[i] * r[0][j] + b[3+i] * r[1][j]
                                         + b[6+i] * r[2][j]);
        end
        res = {o[0], o[1], o[2], o[3], o[4], o[5], o[6], o[7], o[8]};
        return res;
    endfunction

    // sends one word, gap first, with the predicted result queued on accept;
    // valid stays up after the accept so words can follow back to back
    task automatic send_word(input t_erb_in d);
        while (($urandom % 100) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= d;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        rotated_q.push_back('{rotate_basis(d), d});
        @(negedge i_clk);
    endtask

    // output side stalls at random
    always @(negedge i_clk)
        out_ch.ready <= i_rst_n && (($urandom % 100) >= idle_pct);

    always @(posedge i_clk) begin
        t_rot_expect e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (rotated_q.size() == 0) begin
                $display("%0t: unexpected word %h", $time, out_ch.data);
                n_errors++;
            end else begin
                e = rotated_q.pop_front();
                if (out_ch.data !== e.res) begin
                    $display("%0t: mismatch for input %h expected %h actual %h",
                             $time, e.src, e.res, out_ch.data);
                    n_errors++;
                end
            end
        end
    end

    function automatic logic [15:0] rand_ext();
        unique case ($urandom % 5)
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_erb_in rand_word(input bit unit_basis);
        t_erb_in d;
        d = t_erb_in'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        if (unit_basis) begin
            // narrow the diagonal entries right_x, up_y and at_z to -16384..16383; the rest stay random
            d.right_x = 16'($urandom_range(0, 32767) - 16384);
            d.up_y    = 16'($urandom_range(0, 32767) - 16384);
            d.at_z    = 16'($urandom_range(0, 32767) - 16384);
        end
        if (($urandom % 8) == 0) d.angle_x = '0;
        if (($urandom % 8) == 0) d.angle_y = '0;
        if (($urandom % 8) == 0) d.angle_z = '0;
        return d;
    endfunction

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (rotated_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_directed();
        t_erb_in d;
        logic signed [15:0] angs [6] = '{16'sh0000, 16'sh7fff, 16'sh8000,
                                        16'sd6434, -16'sd6434, 16'sd12868};
        d = '0;
        d.right_x = 16'sd16384; d.up_y = 16'sd16384; d.at_z = 16'sd16384;
        for (int k = 0; k < 6; k++) begin
            d.angle_x = angs[k]; d.angle_y = angs[(k+1)%6]; d.angle_z = angs[(k+3)%6];
            send_word(d);
        end
        // identity angles pass any basis, extremes included
        d = {{9{16'h8000}}, 48'h0};
        send_word(d);
        d = {{9{16'h7fff}}, 48'h0};
        send_word(d);
        // saturation both ways
        d = {{9{16'h7fff}}, 16'sd800, 16'sd800, 16'sd800};
        send_word(d);
        d = {{9{16'h8000}}, 16'sd800, 16'sd800, 16'sd800};
        send_word(d);
        for (int k = 0; k < 12; k++) begin
            d = {rand_ext(), rand_ext(), rand_ext(), rand_ext(), rand_ext(), rand_ext(),
                 rand_ext(), rand_ext(), rand_ext(), rand_ext(), rand_ext(), rand_ext()};
            send_word(d);
        end
    endtask

    task automatic test_random(input int n);
        for (int k = 0; k < n; k++) send_word(rand_word(($urandom % 4) != 0));
    endtask

    task automatic test_back_to_back(input int n);
        idle_pct = 0;
        test_random(n);
        idle_pct = 13;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        wait_drained();
        test_random(400);
        test_back_to_back(250);
        wait_drained();
        test_random(380);
        wait_drained();
        repeat (ERB_LAT + 10) @(negedge i_clk);
        if (n_errors == 0 && rotated_q.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end
endmodule
